// ----- rtl/rtps_pkg.sv -----
// shared widths, register indexes and pipeline payload types for the range-to-percent scaler
package rtps_pkg;

	localparam int DW          = 32;
	localparam int FW          = 31;
	localparam int SCALE_SHIFT = 16;
	localparam int MW          = DW + SCALE_SHIFT;
	localparam int CW          = 2;
	localparam int SCALED_LIMIT = 65536;

	localparam logic [CW-1:0] CFG_MAX_PERCENT = CW'(0);
	localparam logic [CW-1:0] CFG_MIN_VALUE   = CW'(1);
	localparam logic [CW-1:0] CFG_MAX_VALUE   = CW'(2);

	localparam logic [FW-1:0] MAX_PERCENT_RST = FW'(100);
	localparam logic [DW-1:0] MIN_VALUE_RST   = DW'(0);
	localparam logic [DW-1:0] MAX_VALUE_RST   = DW'(1023);

	typedef struct packed {
		logic [MW-1:0] rem;
		logic [MW-1:0] dvd;
		logic [MW-1:0] quo;
		logic [MW-1:0] dvs;
	} div_t;

	typedef struct packed {
		logic [MW-1:0] num_mag;
		logic [FW-1:0] full;
		logic          neg;
		logic          err;
	} side_t;

endpackage

// ----- rtl/range_to_percent_scaler.sv -----
// top level: config registers, front stages, two divider cell chains and output register
// pipeline: 3 front stages, 48 + 48 divider cells, 1 output register
// throughput: one beat per cycle; the whole chain advances together whenever the output
// register is empty or being taken
// reset: clears all valid flags and loads max_percent 100, min_value 0, max_value 1023
module range_to_percent_scaler import rtps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] sample,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [FW-1:0] scaled,
	output logic          div_error,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [CW-1:0] cfg_index,
	input  logic [DW-1:0] cfg_data
);

	logic [FW-1:0] max_percent_q;
	logic [DW-1:0] min_value_q, max_value_q;
	logic          en;

	logic          v1   [MW+1];
	div_t          d1   [MW+1];
	side_t         s1   [MW+1];
	logic          v2   [MW+1];
	div_t          d2   [MW+1];
	side_t         s2   [MW+1];

	logic          out_valid_q, div_error_q;
	logic [FW-1:0] scaled_q;
	logic          res_err;
	logic [MW-1:0] q2;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_percent_q <= MAX_PERCENT_RST;
			min_value_q   <= MIN_VALUE_RST;
			max_value_q   <= MAX_VALUE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_PERCENT: max_percent_q <= cfg_data[FW-1:0];
				CFG_MIN_VALUE:   min_value_q   <= cfg_data;
				CFG_MAX_VALUE:   max_value_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	rtps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.sample     (sample),
		.max_percent(max_percent_q),
		.min_value  (min_value_q),
		.max_value  (max_value_q),
		.out_valid  (v1[0]),
		.out_d      (d1[0]),
		.out_side   (s1[0])
	);

	// step divisor: scaled range over full scale
	for (genvar i = 0; i < MW; i++) begin : g_div1
		rtps_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v1[i]),
			.in_d     (d1[i]),
			.in_side  (s1[i]),
			.out_valid(v1[i+1]),
			.out_d    (d1[i+1]),
			.out_side (s1[i+1])
		);
	end

	always_comb begin
		v2[0]     = v1[MW];
		d2[0].rem = '0;
		d2[0].dvd = s1[MW].num_mag;
		d2[0].quo = '0;
		d2[0].dvs = d1[MW].quo;
		s2[0]     = s1[MW];
		s2[0].err = s1[MW].err || (d1[MW].quo == '0);
	end

	// offset over step divisor
	for (genvar i = 0; i < MW; i++) begin : g_div2
		rtps_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v2[i]),
			.in_d     (d2[i]),
			.in_side  (s2[i]),
			.out_valid(v2[i+1]),
			.out_d    (d2[i+1]),
			.out_side (s2[i+1])
		);
	end

	assign q2      = d2[MW].quo;
	assign res_err = s2[MW].err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v2[MW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_error_q <= res_err;
			if (res_err || s2[MW].neg) begin
				scaled_q <= '0;
			end else if (q2 > MW'(s2[MW].full)) begin
				scaled_q <= s2[MW].full;
			end else begin
				scaled_q <= q2[FW-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign scaled    = scaled_q;
	assign div_error = div_error_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && div_error_q |-> scaled_q == '0)
		else $error("error beat with nonzero result");

	a_full_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v2[MW] |-> s2[MW].err || s2[MW].full != '0)
		else $error("zero full scale without error flag");

	a_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && en |=> !out_valid_q || scaled_q <= $past(s2[MW].full) ||
			!$past(v2[MW]))
		else $error("result above full scale");

endmodule

// ----- rtl/rtps_front.sv -----
// clamp, offset, range and magnitude stages ahead of the divider chains
module rtps_front import rtps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] sample,
	input  logic [FW-1:0] max_percent,
	input  logic [DW-1:0] min_value,
	input  logic [DW-1:0] max_value,
	output logic          out_valid,
	output div_t          out_d,
	output side_t         out_side
);

	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [DW-1:0] x_s1, lo_s1, hi_s1;
	logic [FW-1:0]        full_s1, full_s2;
	logic signed [DW:0]   num_s2, range_s2;
	logic                 small_s2, err_s2;
	div_t                 d_s3;
	side_t                side_s3;

	logic signed [DW-1:0] x_c, lo_c, hi_c, x_clamp;
	logic signed [DW:0]   hi_x, num_c, range_c;
	logic [DW-1:0]        nmag, rmag;

	assign x_c  = $signed(sample);
	assign lo_c = $signed(min_value);
	assign hi_c = $signed(max_value);

	always_comb begin
		if (x_c > hi_c) begin
			x_clamp = hi_c;
		end else if (x_c < lo_c) begin
			x_clamp = lo_c;
		end else begin
			x_clamp = x_c;
		end
	end

	assign hi_x    = {hi_s1[DW-1], hi_s1};
	assign num_c   = {x_s1[DW-1], x_s1} - {lo_s1[DW-1], lo_s1};
	assign range_c = hi_x - {lo_s1[DW-1], lo_s1};

	assign nmag = num_s2[DW]   ? DW'(-num_s2)   : DW'(num_s2);
	assign rmag = range_s2[DW] ? DW'(-range_s2) : DW'(range_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= x_clamp;
			lo_s1    <= lo_c;
			hi_s1    <= hi_c;
			full_s1  <= max_percent;
			num_s2   <= num_c;
			range_s2 <= range_c;
			small_s2 <= hi_x < $signed((DW+1)'(SCALED_LIMIT));
			err_s2   <= (full_s1 == '0);
			full_s2  <= full_s1;
			d_s3.rem <= '0;
			d_s3.quo <= '0;
			d_s3.dvs <= MW'(full_s2);
			d_s3.dvd <= small_s2 ? {rmag, SCALE_SHIFT'(0)} : MW'(rmag);
			side_s3.num_mag <= small_s2 ? {nmag, SCALE_SHIFT'(0)} : MW'(nmag);
			side_s3.full    <= full_s2;
			side_s3.neg     <= num_s2[DW] ^ range_s2[DW];
			side_s3.err     <= err_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_d     = d_s3;
	assign out_side  = side_s3;

endmodule

// ----- rtl/rtps_div_cell.sv -----
// one restoring-division cell: develops one quotient bit and hands on to the next cell
module rtps_div_cell import rtps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  div_t  in_d,
	input  side_t in_side,
	output logic  out_valid,
	output div_t  out_d,
	output side_t out_side
);

	logic          valid_q;
	div_t          d_q;
	side_t         side_q;
	logic [MW:0]   trial, diff;
	logic          qbit;

	assign trial = {in_d.rem, in_d.dvd[MW-1]};
	assign diff  = trial - {1'b0, in_d.dvs};
	assign qbit  = !diff[MW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q.rem <= qbit ? diff[MW-1:0] : trial[MW-1:0];
			d_q.dvd <= {in_d.dvd[MW-2:0], 1'b0};
			d_q.quo <= {in_d.quo[MW-2:0], qbit};
			d_q.dvs <= in_d.dvs;
			side_q  <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_d     = d_q;
	assign out_side  = side_q;

endmodule
